[rtl/ace_pkg.sv]
// Shared types and constants for the ARP cache engine.
// Used by ace_cell and arp_cache_engine; depends on nothing else.
package ace_pkg;

    // Index fields are sized for the largest supported table (1024 entries).
    localparam int IDX_MAX_W = 10;

    // Command codes carried on the input tuser.
    localparam logic [2:0] MODE_LOOKUP = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_DELETE = 3'd2;
    localparam logic [2:0] MODE_CLEAR  = 3'd3;
    localparam logic [2:0] MODE_PACKET = 3'd4;

    // ARP opcodes.
    localparam logic [15:0] OPC_REQUEST = 16'd1;
    localparam logic [15:0] OPC_REPLY   = 16'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_OP    = 2'd3;

    // Operation that a token performs as it walks the cell chain.
    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Token handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic                 live;
        cmd_t                 cmd;
        logic [31:0]          key;
        logic                 hit;
        logic [47:0]          hit_mac;
        logic [IDX_MAX_W-1:0] hit_idx;
        logic                 free_found;
        logic [IDX_MAX_W-1:0] free_idx;
    } tok_t;

    // Write broadcast from the controller into one selected cell.
    typedef struct packed {
        logic                 en;
        logic [IDX_MAX_W-1:0] idx;
        logic [31:0]          ip;
        logic [47:0]          mac;
    } wr_t;

endpackage

[rtl/ace_cell.sv]
// One table entry of the ARP cache: valid flag, IPv4 address and MAC.
// Passes the search token on to its neighbor each cycle. Depends on ace_pkg.
module ace_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ace_pkg::tok_t tok_in,
    input  ace_pkg::wr_t  wr,
    output ace_pkg::tok_t tok_out
);
    import ace_pkg::*;

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(CELL_IDX);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        match;
    logic        wr_sel;

    assign match  = valid_reg && (ip_reg == tok_in.key);
    assign wr_sel = wr.en && (wr.idx == MY_IDX);

    // Token update and entry valid flag.
    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        if (tok_in.live)
        begin
            case (tok_in.cmd)
                CMD_LOOKUP, CMD_SEARCH:
                begin
                    if (match && !tok_in.hit)
                    begin
                        tok_next.hit     = 1'b1;
                        tok_next.hit_mac = mac_reg;
                        tok_next.hit_idx = MY_IDX;
                    end
                    if (!valid_reg && !tok_in.free_found)
                    begin
                        tok_next.free_found = 1'b1;
                        tok_next.free_idx   = MY_IDX;
                    end
                end
                CMD_DELETE:
                begin
                    if (match)
                    begin
                        tok_next.hit = 1'b1;
                        valid_next   = 1'b0;
                    end
                end
                CMD_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
        if (wr_sel)
        begin
            valid_next = 1'b1;
        end
    end

    // Control state: valid flag and the token held in this cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // Entry contents.
    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            ip_reg  <= wr.ip;
            mac_reg <= wr.mac;
        end
    end

    assign tok_out = tok_reg;

endmodule

[rtl/arp_cache_engine.sv]
// ARP cache engine top level: command decode, result register, APB register.
// Instantiates a chain of ace_cell entries; depends on ace_pkg.
//
// Usage: commands arrive on the s_ stream (tuser holds the mode, tdata the
// addresses, opcode and target). Each item yields one result on the m_
// stream. Lookup, insert, delete, clear and received ARP packets all run
// by sending one token down the row of TABLE_ENTRIES cells, one cell per
// cycle, so the walk of the chain sets the time per item. A write to the
// table happens in the cycle the token leaves the last cell.
// An unknown mode or opcode skips the walk and goes straight to the
// result. The block takes one item at a time: s_tready is high only
// while idle, so a new item is accepted only once the last result has
// been loaded into the output register.
// A finished result sits in the output register while the next item is
// accepted and walked; a stalled receiver only holds the next result.
// Reset clears every valid flag, own_ip and the handshakes; entry contents
// are written before they are ever read. own_ip is at APB address 0.
module arp_cache_engine #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // Command stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // key_ip[31:0], mac_in[79:32],
                                   // arp_opcode[95:80], target_ip[127:96]
    input  logic [2:0]   s_tuser,  // mode[2:0]
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // mac_out[47:0], reply_mac[95:48],
                                   // reply_ip[127:96]
    output logic [3:0]   m_tuser,  // status[1:0], hit[2], send_reply[3]
    // Register port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ace_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t       state_reg;
    state_t       state_next;

    logic [31:0]  own_ip_reg;

    // Held command.
    logic [2:0]   mode_reg;
    logic [31:0]  key_reg;
    logic [47:0]  mac_reg;
    logic [15:0]  opc_reg;
    logic [31:0]  tgt_reg;

    // Pending result.
    logic [1:0]   res_status_reg;
    logic [1:0]   res_status_next;
    logic         res_hit_reg;
    logic         res_hit_next;
    logic [47:0]  res_mac_reg;
    logic [47:0]  res_mac_next;
    logic         res_send_reg;
    logic         res_send_next;
    logic         res_load;

    // Output register.
    logic         m_tvalid_reg;
    logic         m_tvalid_next;
    logic [127:0] m_tdata_reg;
    logic [3:0]   m_tuser_reg;
    logic         out_load;

    logic         in_accept;
    logic         in_walk;
    cmd_t         in_cmd;
    logic [2:0]   in_mode;
    logic [15:0]  in_opc;

    tok_t         tok_launch;
    tok_t         tok_chain [TABLE_ENTRIES+1];
    tok_t         tok_end;
    wr_t          wr;

    // Register port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? own_ip_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= 32'd0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            own_ip_reg <= pwdata;
        end
    end

    // Command decode at acceptance.
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_mode   = s_tuser;
    assign in_opc    = s_tdata[95:80];

    always_comb
    begin
        in_walk = 1'b1;
        in_cmd  = CMD_LOOKUP;
        case (in_mode)
            MODE_LOOKUP: in_cmd = CMD_LOOKUP;
            MODE_INSERT: in_cmd = CMD_SEARCH;
            MODE_DELETE: in_cmd = CMD_DELETE;
            MODE_CLEAR:  in_cmd = CMD_CLEAR;
            MODE_PACKET:
            begin
                in_cmd  = CMD_SEARCH;
                in_walk = (in_opc == OPC_REQUEST) || (in_opc == OPC_REPLY);
            end
            default:     in_walk = 1'b0;
        endcase
    end

    // Token launched into the first cell.
    always_comb
    begin
        tok_launch      = '0;
        tok_launch.live = in_accept && in_walk;
        tok_launch.cmd  = in_cmd;
        tok_launch.key  = s_tdata[31:0];
    end

    assign tok_chain[0] = tok_launch;

    // Row of table cells.
    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        ace_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[g]),
            .wr      (wr),
            .tok_out (tok_chain[g+1])
        );
    end

    assign tok_end = tok_chain[TABLE_ENTRIES];

    // Result and table write when the token leaves the last cell; bad-op result at acceptance.
    always_comb
    begin
        wr              = '0;
        wr.ip           = key_reg;
        wr.mac          = mac_reg;
        res_load        = 1'b0;
        res_status_next = ST_OK;
        res_hit_next    = 1'b0;
        res_mac_next    = 48'd0;
        res_send_next   = 1'b0;
        if (in_accept && !in_walk)
        begin
            res_load        = 1'b1;
            res_status_next = ST_BAD_OP;
        end
        else if ((state_reg == S_SCAN) && tok_end.live)
        begin
            res_load = 1'b1;
            case (tok_end.cmd)
                CMD_LOOKUP:
                begin
                    res_hit_next    = tok_end.hit;
                    res_mac_next    = tok_end.hit ? tok_end.hit_mac : 48'd0;
                    res_status_next = tok_end.hit ? ST_OK : ST_NOT_FOUND;
                end
                CMD_DELETE:
                begin
                    res_status_next = tok_end.hit ? ST_OK : ST_NOT_FOUND;
                end
                CMD_SEARCH:
                begin
                    if (tok_end.hit)
                    begin
                        wr.en  = 1'b1;
                        wr.idx = tok_end.hit_idx;
                    end
                    else if (tok_end.free_found)
                    begin
                        wr.en  = 1'b1;
                        wr.idx = tok_end.free_idx;
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                    end
                    res_send_next = (mode_reg == MODE_PACKET) &&
                                    (opc_reg == OPC_REQUEST) &&
                                    (tgt_reg == own_ip_reg);
                end
                default:
                begin
                    res_status_next = ST_OK;
                end
            endcase
        end
    end

    // Sequencer.
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = in_walk ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                if (tok_end.live)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Held command, pending result and output payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg <= in_mode;
            key_reg  <= s_tdata[31:0];
            mac_reg  <= s_tdata[79:32];
            opc_reg  <= in_opc;
            tgt_reg  <= s_tdata[127:96];
        end
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_hit_reg    <= res_hit_next;
            res_mac_reg    <= res_mac_next;
            res_send_reg   <= res_send_next;
        end
        if (out_load)
        begin
            m_tdata_reg[47:0]   <= res_mac_reg;
            m_tdata_reg[95:48]  <= res_send_reg ? mac_reg : 48'd0;
            m_tdata_reg[127:96] <= res_send_reg ? key_reg : 32'd0;
            m_tuser_reg         <= {res_send_reg, res_hit_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks.
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register is not one-hot");

    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok_end.live |-> (state_reg == S_SCAN))
        else $error("token left the chain outside a scan");

    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == S_SCAN) && tok_end.live &&
                  (tok_end.cmd == CMD_SEARCH))
        else $error("table write outside the end of a search");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid_reg && (state_reg == S_IDLE))
        else $error("result load did not present an item");

endmodule
